// ----- rtl/core/http_host_header_extractor_defines.svh -----
// assertion macros for the http host header extractor
// used by the top level only, no other dependencies
`ifndef HTTP_HOST_HEADER_EXTRACTOR_DEFINES_SVH
`define HTTP_HOST_HEADER_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HHE_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("hhe same-cycle check failed");

// next-cycle implication, checked out of reset
`define HHE_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("hhe next-cycle check failed");

`endif

// ----- rtl/core/hhe_pkg.sv -----
// shared types, constants and helpers of the http host header extractor
// no dependencies
`default_nettype none

package hhe_pkg;

    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 9;
    localparam int HEADER_LIMIT = 256;
    localparam int MIN_HOST     = 3;
    localparam int PAT_LEN      = 5;
    localparam int PAT_IDX_W    = 3;
    localparam int QPTR_W       = 2;
    localparam int QUEUE_DEPTH  = 1 << QPTR_W;

    localparam logic [CNT_W-1:0] MAX_LEN_RESET = CNT_W'(255);

    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // one queue entry: the results caused by one payload byte
    typedef struct packed {
        logic              has_char;
        logic [BYTE_W-1:0] host_char;
        logic              has_status;
        logic              found;
        logic [CNT_W-1:0]  length;
    } queue_entry_t;

    // front to queue
    typedef struct packed {
        logic         push;
        queue_entry_t entry;
    } queue_wr_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [BYTE_W-1:0] lower_of(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    // characters of "host:"
    function automatic logic [BYTE_W-1:0] pattern_char(input logic [PAT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] r;
        case (idx)
            3'd0:    r = 8'h68;
            3'd1:    r = 8'h6F;
            3'd2:    r = 8'h73;
            3'd3:    r = 8'h74;
            3'd4:    r = CH_COLON;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hhe_if.sv -----
// request channels of the http host header extractor
// depends on hhe_pkg
`default_nettype none

interface hhe_in_if;
    logic                          valid;
    logic                          ready;
    logic [hhe_pkg::BYTE_W-1:0]    data_byte;
    logic                          end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface hhe_out_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [hhe_pkg::BYTE_W-1:0]    host_char;
    logic                          host_found;
    logic [hhe_pkg::CNT_W-1:0]     host_length;
    logic                          last_result;

    modport source (output valid, output result_kind, output host_char, output host_found,
                    output host_length, output last_result, input ready);
    modport sink   (input valid, input result_kind, input host_char, input host_found,
                    input host_length, input last_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hhe_front.sv -----
// front part: takes payload bytes, runs the header search and capture,
// pushes the results of each byte into the queue; depends on hhe_pkg, hhe_if
`default_nettype none

module hhe_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    hhe_in_if.sink                          payload,
    input  wire logic                       cfg_we,
    input  wire logic [hhe_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire hhe_pkg::queue_stat_t       q_stat,
    output hhe_pkg::queue_wr_t              q_wr
);

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SKIP,
        PH_CAPTURE,
        PH_DONE
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [hhe_pkg::PAT_IDX_W-1:0]   match_reg, match_next;
    logic [hhe_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            matched_reg, matched_next;
    logic [hhe_pkg::CNT_W-1:0]       max_len_reg, max_len_next;

    logic [hhe_pkg::CNT_W-1:0]       limit;
    logic [hhe_pkg::BYTE_W-1:0]      c;
    logic [hhe_pkg::BYTE_W-1:0]      lc;
    logic [hhe_pkg::PAT_IDX_W-1:0]   p;
    logic                            accept;
    logic                            emit_char;
    logic                            stop;

    assign payload.ready = !q_stat.full;
    assign accept        = payload.valid && payload.ready;
    assign c             = payload.data_byte;
    assign lc            = hhe_pkg::lower_of(c);

    // effective limit is the smaller of the register and the header limit
    assign limit = (int'(max_len_reg) < hhe_pkg::HEADER_LIMIT) ? max_len_reg
                 : hhe_pkg::CNT_W'(hhe_pkg::HEADER_LIMIT);

    assign stop = (count_reg >= limit) || (c == hhe_pkg::CH_COLON) || (c == hhe_pkg::CH_CR)
               || (c == hhe_pkg::CH_LF) || (c < hhe_pkg::CH_PRINT_LO)
               || (c > hhe_pkg::CH_PRINT_HI);

    assign max_len_next = cfg_we ? cfg_wdata : max_len_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        match_next   = match_reg;
        count_next   = count_reg;
        matched_next = matched_reg;
        emit_char    = 1'b0;
        p            = match_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (c == hhe_pkg::CH_NUL)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (lc == hhe_pkg::pattern_char(match_reg))
                        begin
                            p = match_reg + 1'b1;
                        end
                        else if (lc == hhe_pkg::pattern_char('0))
                        begin
                            p = hhe_pkg::PAT_IDX_W'(1);
                        end
                        else
                        begin
                            p = '0;
                        end
                        if (p == hhe_pkg::PAT_IDX_W'(hhe_pkg::PAT_LEN))
                        begin
                            phase_next = PH_SKIP;
                            p          = '0;
                        end
                        match_next = p;
                    end
                end
                PH_SKIP:
                begin
                    if (c == hhe_pkg::CH_NUL)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        matched_next = 1'b1;
                        phase_next   = PH_CAPTURE;
                    end
                end
                PH_CAPTURE:
                begin
                    if (stop)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        emit_char  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        q_wr.push             = accept && (emit_char || payload.end_of_packet);
        q_wr.entry.has_char   = emit_char;
        q_wr.entry.host_char  = c;
        q_wr.entry.has_status = payload.end_of_packet;
        q_wr.entry.found      = matched_next
                             && (count_next >= hhe_pkg::CNT_W'(hhe_pkg::MIN_HOST));
        q_wr.entry.length     = count_next;

        // packet end returns the search to its start
        if (accept && payload.end_of_packet)
        begin
            phase_next   = PH_SEARCH;
            match_next   = '0;
            count_next   = '0;
            matched_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEARCH;
            match_reg   <= '0;
            count_reg   <= '0;
            matched_reg <= 1'b0;
            max_len_reg <= hhe_pkg::MAX_LEN_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            match_reg   <= match_next;
            count_reg   <= count_next;
            matched_reg <= matched_next;
            max_len_reg <= max_len_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/hhe_queue.sv -----
// short queue between front and back, entries held in flops
// depends on hhe_pkg
`default_nettype none

module hhe_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hhe_pkg::queue_wr_t    q_wr,
    input  wire logic                  pop,
    output hhe_pkg::queue_entry_t      head,
    output hhe_pkg::queue_stat_t       q_stat
);

    hhe_pkg::queue_entry_t           entry_reg [hhe_pkg::QUEUE_DEPTH];
    logic [hhe_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hhe_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hhe_pkg::QPTR_W:0]        count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign q_stat.full  = (count_reg == (hhe_pkg::QPTR_W+1)'(hhe_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    assign do_push = q_wr.push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/hhe_back.sv -----
// back part: drains the queue into the output register, one result a cycle while
// the receiver takes them, host byte first and status second; depends on hhe_pkg, hhe_if
`default_nettype none

module hhe_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire hhe_pkg::queue_entry_t   head,
    input  wire hhe_pkg::queue_stat_t    q_stat,
    output logic                         pop,
    hhe_out_if.source                    result
);

    logic                            valid_reg, valid_next;
    logic                            pend_reg, pend_next;
    logic                            pend_found_reg, pend_found_next;
    logic [hhe_pkg::CNT_W-1:0]       pend_len_reg, pend_len_next;
    logic                            kind_reg, kind_next;
    logic [hhe_pkg::BYTE_W-1:0]      char_reg, char_next;
    logic                            found_reg, found_next;
    logic [hhe_pkg::CNT_W-1:0]       len_reg, len_next;
    logic                            last_reg, last_next;
    logic                            load_ok;

    assign load_ok = !valid_reg || result.ready;

    always_comb
    begin
        pop             = 1'b0;
        valid_next      = valid_reg;
        pend_next       = pend_reg;
        pend_found_next = pend_found_reg;
        pend_len_next   = pend_len_reg;
        kind_next       = kind_reg;
        char_next       = char_reg;
        found_next      = found_reg;
        len_next        = len_reg;
        last_next       = last_reg;

        if (load_ok)
        begin
            if (pend_reg)
            begin
                // status held back behind a host byte of the same packet end
                valid_next = 1'b1;
                pend_next  = 1'b0;
                kind_next  = hhe_pkg::KIND_STATUS;
                char_next  = '0;
                found_next = pend_found_reg;
                len_next   = pend_len_reg;
                last_next  = 1'b1;
            end
            else if (!q_stat.empty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                if (head.has_char)
                begin
                    kind_next       = hhe_pkg::KIND_CHAR;
                    char_next       = head.host_char;
                    found_next      = 1'b0;
                    len_next        = '0;
                    last_next       = 1'b0;
                    pend_next       = head.has_status;
                    pend_found_next = head.found;
                    pend_len_next   = head.length;
                end
                else
                begin
                    kind_next  = hhe_pkg::KIND_STATUS;
                    char_next  = '0;
                    found_next = head.found;
                    len_next   = head.length;
                    last_next  = 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_found_reg <= pend_found_next;
        pend_len_reg   <= pend_len_next;
        kind_reg       <= kind_next;
        char_reg       <= char_next;
        found_reg      <= found_next;
        len_reg        <= len_next;
        last_reg       <= last_next;
    end

    assign result.valid       = valid_reg;
    assign result.result_kind = kind_reg;
    assign result.host_char   = char_reg;
    assign result.host_found  = found_reg;
    assign result.host_length = len_reg;
    assign result.last_result = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/http_host_header_extractor.sv -----
// http host header extractor, top level
// depends on hhe_pkg, hhe_if, hhe_front, hhe_queue, hhe_back and the defines header
//
// usage:
// - payload channel takes one packet byte per request (data_byte, end_of_packet);
//   a zero byte ends the searchable text, end_of_packet marks the last byte
// - result channel sends captured host bytes (result_kind 0) and, on each packet
//   end, one status request (result_kind 1, last_result 1, host_found, host_length)
// - cfg_we/cfg_wdata write max_host_len; write it only while the block is idle
// - throughput: one payload byte per cycle while the queue is not full; a byte that
//   yields both a host byte and a status leaves them in turn through the output register
// - result path: a result is written into the queue when its byte is taken, then
//   loaded from the queue into the output register
// - receiver stall: the four-entry queue keeps taking bytes, payload ready drops
//   only when the queue is full
// - reset: search restarts, queue and output are empty, max_host_len is 255;
//   no clearing pass is needed
`default_nettype none
`include "http_host_header_extractor_defines.svh"

module http_host_header_extractor (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    hhe_in_if.sink                          payload,
    hhe_out_if.source                       result,
    input  wire logic                       cfg_we,
    input  wire logic [hhe_pkg::CNT_W-1:0]  cfg_wdata
);

    hhe_pkg::queue_wr_t     q_wr;
    hhe_pkg::queue_stat_t   q_stat;
    hhe_pkg::queue_entry_t  q_head;
    logic                   q_pop;

    // search and capture, one byte per cycle while the queue is not full
    hhe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .payload   (payload),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .q_wr      (q_wr)
    );

    // decouples byte intake from result delivery
    hhe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .pop    (q_pop),
        .head   (q_head),
        .q_stat (q_stat)
    );

    // splits entries into single results
    hhe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (q_pop),
        .result (result)
    );

    // a full queue is never empty
    `HHE_ASSERT_IMP(a_queue_flags, clk, rst_n, q_stat.full, !q_stat.empty)

    // a status request carries no host byte and closes the packet
    `HHE_ASSERT_IMP(a_status_shape, clk, rst_n,
        result.valid && (result.result_kind == hhe_pkg::KIND_STATUS),
        (result.host_char == '0) && result.last_result)

    // found implies the minimum host length
    `HHE_ASSERT_IMP(a_found_len, clk, rst_n, result.valid && result.host_found,
        result.host_length >= hhe_pkg::CNT_W'(hhe_pkg::MIN_HOST))

    // a push into a full queue would lose a result
    `HHE_ASSERT_NXT(a_no_drop, clk, rst_n, q_stat.full && !q_pop, !q_stat.empty)

endmodule

`default_nettype wire

// ----- dv/hhe_capture_check.sv -----
// host header extraction checker: watches the payload and result channels,
// predicts each result from the accepted payload bytes and compares them
// depends on hhe_pkg and hhe_if
`default_nettype none

module hhe_capture_check
    import hhe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CNT_W-1:0] cfg_wdata,
    hhe_in_if                     payload,
    hhe_out_if                    result,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        SCAN_SEARCH,
        SCAN_SKIP,
        SCAN_CAPTURE,
        SCAN_DONE
    } scan_phase_e;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] host_char;
        logic              found;
        logic [CNT_W-1:0]  length;
        logic              last;
    } host_result_t;

    // "host:" in lower case
    localparam logic [BYTE_W-1:0] HOST_TAG [PAT_LEN] = '{8'h68, 8'h6F, 8'h73, 8'h74, CH_COLON};

    scan_phase_e       scan_phase;
    logic [2:0]        tag_matched;
    logic [CNT_W-1:0]  host_count;
    logic              header_seen;
    logic [CNT_W-1:0]  host_limit;
    host_result_t      expected_results [$];

    task automatic clear_scan();
        scan_phase  = SCAN_SEARCH;
        tag_matched = '0;
        host_count  = '0;
        header_seen = 1'b0;
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] c, input logic eop);
        logic [BYTE_W-1:0] folded;
        int                progress;
        int                cap;
        host_result_t      r;
        folded = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
        cap = (host_limit < HEADER_LIMIT) ? int'(host_limit) : HEADER_LIMIT;
        case (scan_phase)
            SCAN_SEARCH:
            begin
                if (c == CH_NUL)
                begin
                    scan_phase = SCAN_DONE;
                end
                else
                begin
                    progress = (tag_matched < PAT_LEN) ? int'(tag_matched) : 0;
                    if (folded == HOST_TAG[progress])
                    begin
                        progress++;
                    end
                    else
                    begin
                        progress = (folded == HOST_TAG[0]) ? 1 : 0;
                    end
                    if (progress == PAT_LEN)
                    begin
                        scan_phase = SCAN_SKIP;
                        progress   = 0;
                    end
                    tag_matched = 3'(progress);
                end
            end
            SCAN_SKIP:
            begin
                if (c == CH_NUL)
                begin
                    scan_phase = SCAN_DONE;
                end
                else
                begin
                    header_seen = 1'b1;
                    scan_phase  = SCAN_CAPTURE;
                end
            end
            SCAN_CAPTURE:
            begin
                if (host_count >= cap || c == CH_COLON || c == CH_CR || c == CH_LF ||
                    c < CH_PRINT_LO || c > CH_PRINT_HI)
                begin
                    scan_phase = SCAN_DONE;
                end
                else
                begin
                    r = '{kind: KIND_CHAR, host_char: c, found: 1'b0, length: '0, last: 1'b0};
                    expected_results.push_back(r);
                    host_count = host_count + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (eop)
        begin
            r = '{kind: KIND_STATUS, host_char: '0,
                  found: header_seen && host_count >= MIN_HOST,
                  length: host_count, last: 1'b1};
            expected_results.push_back(r);
            clear_scan();
        end
    endtask

    task automatic check_result();
        host_result_t want;
        host_result_t got;
        got = '{kind: result.result_kind, host_char: result.host_char,
                found: result.host_found, length: result.host_length,
                last: result.last_result};
        if (expected_results.size() == 0)
        begin
            fail_count++;
            $display("%0t: expected none", $time);
            $display("%0t:   actual kind=%0d char=%02h found=%0d len=%0d last=%0d",
                     $time, got.kind, got.host_char, got.found, got.length, got.last);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got !== want)
            begin
                fail_count++;
                $display("%0t: expected kind=%0d char=%02h found=%0d len=%0d last=%0d",
                         $time, want.kind, want.host_char, want.found, want.length,
                         want.last);
                $display("%0t:   actual kind=%0d char=%02h found=%0d len=%0d last=%0d",
                         $time, got.kind, got.host_char, got.found, got.length,
                         got.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            host_limit = MAX_LEN_RESET;
            expected_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                host_limit = cfg_wdata;
            end
            if (payload.valid && payload.ready)
            begin
                predict_byte(payload.data_byte, payload.end_of_packet);
            end
            if (result.valid && result.ready)
            begin
                check_result();
            end
            outstanding = expected_results.size();
        end
    end

endmodule

`default_nettype wire

// ----- dv/http_host_header_extractor_test.sv -----
// testbench top of the http host header extractor: clock, reset, payload
// stimulus, receiver stalls and the verdict; checking is in hhe_capture_check
// depends on hhe_pkg, hhe_if, hhe_capture_check and the block itself
`default_nettype none

module http_host_header_extractor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hhe_pkg::*;

    typedef logic [BYTE_W-1:0] payload_bytes_t [$];

    localparam int PHASE_BYTES  = 100;
    localparam int LONG_HOST    = HEADER_LIMIT + 6;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_TICKS = 8;
    localparam int DRAIN_LIMIT  = 5000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    int               fail_count;
    int               outstanding;

    // idling switches and the request for one long receiver hold-off
    logic tx_idle_on;
    logic rx_idle_on;
    logic hold_wanted;

    hhe_in_if  payload_if ();
    hhe_out_if result_if ();

    http_host_header_extractor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .payload   (payload_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    hhe_capture_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .payload     (payload_if),
        .result      (result_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // hard stop in case the block hangs or drops results
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request, none at the end
    initial
    begin
        result_if.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_wanted)
            begin
                // long hold-off so the internal queue fills and payload ready drops
                hold_wanted = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [BYTE_W-1:0] random_printable();
        return BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    endfunction

    function automatic void add_text(ref payload_bytes_t pkt, input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            pkt.push_back(s[i]);
        end
    endfunction

    // mostly well-formed "host:" packets with random content, the rest noise
    function automatic payload_bytes_t random_packet();
        payload_bytes_t    pkt;
        string             tag;
        logic [BYTE_W-1:0] c;
        tag = "host:";
        if ($urandom_range(0, 9) < 7)
        begin
            repeat ($urandom_range(0, 4)) pkt.push_back(random_printable());
            for (int i = 0; i < tag.len(); i++)
            begin
                c = tag[i];
                // random case on the letters, the colon stays exact
                if (c != CH_COLON && $urandom_range(0, 1) == 1)
                begin
                    c = c ^ CASE_OFFSET;
                end
                pkt.push_back(c);
            end
            // the one skipped byte: usually a space, sometimes anything, rarely zero
            case ($urandom_range(0, 9))
                0:       pkt.push_back(CH_NUL);
                1:       pkt.push_back(BYTE_W'($urandom_range(1, 255)));
                default: pkt.push_back(8'h20);
            endcase
            repeat ($urandom_range(0, 8)) pkt.push_back(random_printable());
            // how the host name ends
            case ($urandom_range(0, 6))
                0:       pkt.push_back(CH_COLON);
                1:       pkt.push_back(CH_CR);
                2:       pkt.push_back(CH_LF);
                3:       pkt.push_back(CH_NUL);
                4:       pkt.push_back(BYTE_W'($urandom_range(8'h7F, 8'hFF)));
                5:       pkt.push_back(BYTE_W'($urandom_range(1, 8'h1F)));
                default:
                begin
                end
            endcase
            repeat ($urandom_range(0, 3)) pkt.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            // broken header or plain noise
            if ($urandom_range(0, 3) == 0)
            begin
                add_text(pkt, "HoSt");
            end
            repeat ($urandom_range(1, 12)) pkt.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        return pkt;
    endfunction

    // one payload request; called at a rising edge, returns at the accepting edge
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eop);
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            payload_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        payload_if.valid         <= 1'b1;
        payload_if.data_byte     <= b;
        payload_if.end_of_packet <= eop;
        do
        begin
            @(posedge clk);
        end
        while (!payload_if.ready);
    endtask

    // end_of_packet rides on the last byte
    task automatic send_packet(input payload_bytes_t pkt);
        foreach (pkt[i])
        begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // let every expected result come out, then settle for bytes that cause
    // no result but may still be in flight
    task automatic wait_idle();
        payload_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_host_limit(input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        payload_bytes_t    pkt;
        int                limit_plan [7];
        int                phase_bytes;
        int                waited;
        logic [BYTE_W-1:0] c;

        payload_if.valid         = 1'b0;
        payload_if.data_byte     = '0;
        payload_if.end_of_packet = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        rst_n       = 1'b0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        hold_wanted = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed packets at the reset limit
        // header in mixed case, one host byte, then a non-printable stop
        pkt.delete();
        add_text(pkt, "hOST:xa");
        pkt.push_back(8'h7F);
        send_packet(pkt);
        // zero byte in the skip slot, with a repeated leading letter
        pkt.delete();
        add_text(pkt, "hhost:");
        pkt.push_back(CH_NUL);
        send_packet(pkt);
        // zero byte while searching, then the top byte value as packet end
        pkt.delete();
        pkt.push_back(CH_NUL);
        pkt.push_back(8'hFF);
        send_packet(pkt);
        // printable edges captured, last byte yields a host byte and the status
        pkt.delete();
        add_text(pkt, "Host: ~ z");
        send_packet(pkt);

        // limit settings: zero, tiny, the found threshold, random small,
        // exactly the header limit, the register maximum, back to reset value
        limit_plan = '{0, 1, MIN_HOST, 0, HEADER_LIMIT, (1 << CNT_W) - 1, 255};
        limit_plan[3] = $urandom_range(MIN_HOST + 1, 12);

        foreach (limit_plan[k])
        begin
            wait_idle();
            write_host_limit(CNT_W'(limit_plan[k]));
            if (k == 1)
            begin
                hold_wanted = 1'b1;
            end
            if (k == 6)
            begin
                // last stretch runs without idling on either side
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (limit_plan[k] == HEADER_LIMIT)
            begin
                // one host name longer than the limit, capture stops at the limit
                pkt.delete();
                add_text(pkt, "Host: ");
                repeat (LONG_HOST)
                begin
                    do
                    begin
                        c = random_printable();
                    end
                    while (c == CH_COLON);
                    pkt.push_back(c);
                end
                send_packet(pkt);
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                pkt = random_packet();
                send_packet(pkt);
                phase_bytes += pkt.size();
            end
        end

        payload_if.valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_TICKS) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- http_host_header_extractor.f -----
+incdir+rtl/core
rtl/core/hhe_pkg.sv
rtl/core/hhe_if.sv
rtl/core/hhe_front.sv
rtl/core/hhe_queue.sv
rtl/core/hhe_back.sv
rtl/core/http_host_header_extractor.sv
dv/hhe_capture_check.sv
dv/http_host_header_extractor_test.sv
